@@ src/scalar_kalman_filter_defines.svh @@
// assertion macros used by the checker file
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SKF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SKF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/skf_pkg.sv @@
// shared types and constants of the scalar kalman filter
package skf_pkg;

    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int EST_W     = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE  = 2'd2;

    // reset values of the registers
    localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 18'd66;
    localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 18'd35586;
    localparam logic [CFG_W-1:0] INITIAL_VARIANCE_RST  = 18'd1311;

    localparam logic [EST_W-1:0] EST_POS_MAX = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic [EST_W-1:0] EST_NEG_MIN = {1'b1, {(EST_W-1){1'b0}}};

    localparam int OUT_POS_LIM = 32767;
    localparam int OUT_NEG_LIM = 32768;
    localparam logic [OUT_W-1:0] OUT_MAX_VAL = 16'h7FFF;
    localparam logic [OUT_W-1:0] OUT_MIN_VAL = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } skf_state_t;

    // load / step strobes from the sequencer to a serial unit
    typedef struct packed {
        logic load;
        logic step;
    } skf_step_t;

endpackage

@@ src/scalar_kalman_filter.sv @@
// scalar kalman filter: top level with sequencer, state and result register
//
// usage
//   - s_ channel carries one signed encoder count per transfer, m_ channel
//     returns one signed filtered count per accepted sample
//   - cfg_wr_en / cfg_wr_index / cfg_wr_data write Q, R and the initial
//     variance; writing the initial variance also reloads the error variance;
//     write only while no sample is in flight
//   - a sample passes through the bit-serial divider and then the bit-serial
//     multipliers, FRACTION_BITS+1 steps each, before the result shows on m_
//   - a new sample is taken only once the previous result is registered, so
//     samples are worked on one at a time
//   - the result sits in an output register; the next sample is accepted
//     while it waits, and only the final write-back waits for m_tready
//   - reset clears the estimate, restores the register defaults and loads
//     the error variance with the initial variance
module scalar_kalman_filter #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,      // [15:0] sample_count
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,      // [15:0] filtered_count
    input  logic                          cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [skf_pkg::CFG_W-1:0]     cfg_wr_data
);

    import skf_pkg::*;

    localparam int ONEW = FRACTION_BITS + 1;      // gain width, up to 1.0
    localparam int PRW  = CFG_W + 1;              // prior variance
    localparam int DNW  = CFG_W + 2;              // prior + R
    localparam int SHW  = IN_W + FRACTION_BITS;   // sample in fixed point
    localparam int DW   = ((SHW > EST_W) ? SHW : EST_W) + 1;  // innovation
    localparam int NW   = DW + 2;                 // updated estimate before clipping
    localparam int CW   = $clog2(FRACTION_BITS + 1);
    localparam logic [CW-1:0]   LAST_STEP = CW'(FRACTION_BITS);
    localparam logic [ONEW-1:0] ONE       = {1'b1, {FRACTION_BITS{1'b0}}};

    // configuration and filter state
    logic [CFG_W-1:0] q_reg, r_reg, p0_reg;
    logic [EST_W-1:0] est_reg;
    logic [CFG_W-1:0] var_reg;

    // per-sample working registers
    logic [PRW-1:0]   prior_reg;
    logic [DW-1:0]    mag_reg;
    logic             neg_reg;

    skf_state_t       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_valid_reg, out_valid_next;

    skf_step_t        div_ctl, mul_ctl;
    logic             s_accept, upd_en, out_load, last_step;

    // accept-time arithmetic
    logic [PRW-1:0]   prior_w;
    logic [DNW-1:0]   denom_w;
    logic [SHW-1:0]   sample_sh;
    logic [DW-1:0]    diff_w, mag_w;

    // unit results
    logic [ONEW-1:0]      gain_w, one_minus_gain;
    logic [DW+ONEW-1:0]   gain_prod;
    logic [PRW+ONEW-1:0]  var_prod;

    // update arithmetic
    logic [DW-1:0]    delta_w;
    logic [NW-1:0]    est_ext, delta_ext, next_wide;
    logic [EST_W-1:0] est_sat;
    logic [PRW-1:0]   var_w;
    logic [CFG_W-1:0] var_sat;

    // result formatting
    logic [EST_W-1:0] est_mag, ip_mag, ip_neg;
    logic [OUT_W-1:0] out_w;

    assign s_accept  = s_tvalid && s_tready;
    assign last_step = (cnt_reg == LAST_STEP);

    always_comb begin
        prior_w   = PRW'(var_reg) + PRW'(q_reg);
        denom_w   = DNW'(prior_w) + DNW'(r_reg);
        sample_sh = {s_tdata[IN_W-1:0], {FRACTION_BITS{1'b0}}};
        diff_w    = {{(DW-SHW){sample_sh[SHW-1]}}, sample_sh}
                  - {{(DW-EST_W){est_reg[EST_W-1]}}, est_reg};
        mag_w     = diff_w[DW-1] ? (DW'(0) - diff_w) : diff_w;
    end

    // gain = prior / (prior + R)
    skf_div #(
        .NUM_W (PRW),
        .DEN_W (DNW),
        .Q_W   (ONEW)
    ) u_div (
        .aclk (aclk),
        .ctl  (div_ctl),
        .num  (prior_w),
        .den  (denom_w),
        .quot (gain_w)
    );

    assign one_minus_gain = ONE - gain_w;

    // gain * |innovation|
    skf_mul #(
        .A_W (DW),
        .B_W (ONEW)
    ) u_mul_gain (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .a    (mag_reg),
        .b    (gain_w),
        .prod (gain_prod)
    );

    // (1 - gain) * prior, runs alongside
    skf_mul #(
        .A_W (PRW),
        .B_W (ONEW)
    ) u_mul_var (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .a    (prior_reg),
        .b    (one_minus_gain),
        .prod (var_prod)
    );

    // estimate and variance update with saturation
    always_comb begin
        delta_w   = gain_prod[FRACTION_BITS +: DW];
        est_ext   = {{(NW-EST_W){est_reg[EST_W-1]}}, est_reg};
        delta_ext = {2'b00, delta_w};
        next_wide = neg_reg ? (est_ext - delta_ext) : (est_ext + delta_ext);
        priority if (!next_wide[NW-1] && (|next_wide[NW-2:EST_W-1])) begin
            est_sat = EST_POS_MAX;
        end else if (next_wide[NW-1] && !(&next_wide[NW-2:EST_W-1])) begin
            est_sat = EST_NEG_MIN;
        end else begin
            est_sat = next_wide[EST_W-1:0];
        end
        var_w   = var_prod[FRACTION_BITS +: PRW];
        var_sat = var_w[PRW-1] ? {CFG_W{1'b1}} : var_w[CFG_W-1:0];
    end

    // integer part, truncated toward zero, clipped to 16 bits
    always_comb begin
        est_mag = est_reg[EST_W-1] ? (EST_W'(0) - est_reg) : est_reg;
        ip_mag  = est_mag >> FRACTION_BITS;
        ip_neg  = EST_W'(0) - ip_mag;
        if (est_reg[EST_W-1]) begin
            out_w = (ip_mag > EST_W'(OUT_NEG_LIM)) ? OUT_MIN_VAL : ip_neg[OUT_W-1:0];
        end else begin
            out_w = (ip_mag > EST_W'(OUT_POS_LIM)) ? OUT_MAX_VAL : ip_mag[OUT_W-1:0];
        end
    end

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (last_step) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (last_step) state_next = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_tready     = 1'b0;
        div_ctl      = '0;
        mul_ctl      = '0;
        cnt_next     = '0;
        upd_en       = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                div_ctl.load = s_tvalid;
            end
            ST_DIV: begin
                div_ctl.step = 1'b1;
                cnt_next     = last_step ? '0 : cnt_reg + 1'b1;
            end
            ST_LOAD: begin
                mul_ctl.load = 1'b1;
            end
            ST_MUL: begin
                mul_ctl.step = 1'b1;
                cnt_next     = last_step ? '0 : cnt_reg + 1'b1;
            end
            ST_UPD: begin
                upd_en = 1'b1;
            end
            ST_OUT: begin
                out_load = !out_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result slot empties on a transfer, refills from the estimate
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            q_reg         <= PROCESS_NOISE_RST;
            r_reg         <= MEASUREMENT_NOISE_RST;
            p0_reg        <= INITIAL_VARIANCE_RST;
            est_reg       <= '0;
            var_reg       <= INITIAL_VARIANCE_RST;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_PROCESS_NOISE:     q_reg <= cfg_wr_data;
                    REG_MEASUREMENT_NOISE: r_reg <= cfg_wr_data;
                    REG_INITIAL_VARIANCE: begin
                        p0_reg  <= cfg_wr_data;
                        var_reg <= cfg_wr_data;
                    end
                    default: begin
                        // unused index, write ignored
                        p0_reg <= p0_reg;
                    end
                endcase
            end
            if (upd_en) begin
                est_reg <= est_sat;
                var_reg <= var_sat;
            end
        end
    end

    // per-sample payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            prior_reg <= prior_w;
            mag_reg   <= mag_w;
            neg_reg   <= diff_w[DW-1];
        end
        if (out_load) begin
            out_data_reg <= out_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ src/skf_div.sv @@
// restoring divider, one quotient bit per step, num must not exceed den
module skf_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 20,
    parameter int Q_W   = 17
) (
    input  logic                 aclk,
    input  skf_pkg::skf_step_t   ctl,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic [Q_W-1:0]       quot
);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             den_zero_reg;
    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   kept;
    logic             q_bit;

    always_comb begin
        trial    = {1'b0, rem_reg} - {2'b00, den_reg};
        q_bit    = !trial[DEN_W+1];
        kept     = q_bit ? trial[DEN_W:0] : rem_reg;
        rem_next = {kept[DEN_W-1:0], 1'b0};
        q_next   = {q_reg[Q_W-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg      <= (DEN_W+1)'(num);
            den_reg      <= den;
            den_zero_reg <= (den == '0);
            q_reg        <= '0;
        end else if (ctl.step) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    // zero divisor gives zero gain
    assign quot = den_zero_reg ? '0 : q_reg;

endmodule

@@ src/skf_mul.sv @@
// shift-add multiplier, one multiplier bit per step, lsb first
module skf_mul #(
    parameter int A_W = 33,
    parameter int B_W = 17
) (
    input  logic                 aclk,
    input  skf_pkg::skf_step_t   ctl,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]   prod
);

    logic [A_W+B_W-1:0] prod_reg, prod_next;
    logic [A_W:0]       sum;

    always_comb begin
        sum       = {1'b0, prod_reg[A_W+B_W-1:B_W]} + (prod_reg[0] ? {1'b0, a} : '0);
        prod_next = {sum, prod_reg[B_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_reg <= {{A_W{1'b0}}, b};
        end else if (ctl.step) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ src/skf_chk.sv @@
// port-level checker for the scalar kalman filter, bound to the top level
`include "scalar_kalman_filter_defines.svh"

module skf_chk (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [skf_pkg::OUT_W-1:0] m_tdata
);

    // a stalled result keeps its value
    `SKF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one sample at a time: busy right after a transfer in
    `SKF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a sample is in work")

    // a fresh result only appears at the end of the work on a sample
    `SKF_ASSERT_NOW(a_result_after_work, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "result appeared while idle")

endmodule

bind scalar_kalman_filter skf_chk u_skf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
// self-checking testbench for the scalar kalman filter with its own fixed-point predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    // fixed-point layout at the default build
    localparam int     FRAC     = 16;
    localparam longint ONE      = longint'(1) << FRAC;
    localparam longint FRAC_MSK = ONE - 1;
    localparam longint VAR_MAX  = (longint'(1) << CFG_W) - 1;
    localparam longint EST_HI   = (longint'(1) << (EST_W - 1)) - 1;
    localparam longint EST_LO   = -(longint'(1) << (EST_W - 1));

    // the fourth index on the config port selects no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 400000;

    // mirrors the filter state and holds the filtered counts still owed by the block
    class filter_scoreboard;
        longint q_noise;
        longint r_noise;
        longint p_start;
        longint est;
        longint var_p;
        logic [OUT_W-1:0] expected_counts[$];
        int samples_taken;
        int results_checked;
        int errors;

        function new();
            q_noise         = longint'(PROCESS_NOISE_RST);
            r_noise         = longint'(MEASUREMENT_NOISE_RST);
            p_start         = longint'(INITIAL_VARIANCE_RST);
            est             = 0;
            var_p           = p_start;
            samples_taken   = 0;
            results_checked = 0;
            errors          = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_PROCESS_NOISE:     q_noise = longint'(value);
                REG_MEASUREMENT_NOISE: r_noise = longint'(value);
                REG_INITIAL_VARIANCE: begin
                    p_start = longint'(value);
                    var_p   = longint'(value);
                end
                default: ;
            endcase
        endfunction

        // one predict/update step; pushes the filtered count it yields
        function void take_sample(logic [IN_W-1:0] raw);
            longint prior;
            longint denom;
            longint gain;
            longint diff;
            longint mag;
            longint delta;
            longint nxt;
            longint vnew;
            longint ip;
            prior = var_p + q_noise;
            denom = prior + r_noise;
            gain  = 0;
            // zero denominator leaves the gain at nought
            if (denom != 0) begin
                gain = (prior << FRAC) / denom;
            end
            if (gain > ONE) begin
                gain = ONE;
            end
            diff  = longint'($signed(raw)) * ONE - est;
            mag   = (diff < 0) ? -diff : diff;
            // correction truncated toward zero
            delta = gain * (mag >> FRAC) + ((gain * (mag & FRAC_MSK)) >> FRAC);
            nxt   = (diff < 0) ? est - delta : est + delta;
            if (nxt > EST_HI) nxt = EST_HI;
            if (nxt < EST_LO) nxt = EST_LO;
            est  = nxt;
            vnew = ((ONE - gain) * prior) >> FRAC;
            if (vnew > VAR_MAX) vnew = VAR_MAX;
            var_p = vnew;
            ip = ((est < 0) ? -est : est) >> FRAC;
            if (est < 0) ip = -ip;
            if (ip > OUT_POS_LIM) ip = OUT_POS_LIM;
            if (ip < -OUT_NEG_LIM) ip = -OUT_NEG_LIM;
            expected_counts.push_back(OUT_W'(ip));
            samples_taken++;
        endfunction

        function void check_count(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_counts.size() == 0) begin
                $error("filtered_count: unexpected result, actual %0d", $signed(got));
                errors++;
            end else begin
                want = expected_counts.pop_front();
                results_checked++;
                if (got !== want) begin
                    $error("filtered_count mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata      = '0;   // [15:0] sample_count
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [OUT_W-1:0]     m_tdata;             // [15:0] filtered_count
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data  = '0;

    filter_scoreboard scoreboard = new();

    // idling bounds, redrawn per phase so that some phases run flat out
    int src_gap_max    = 3;
    int sink_stall_max = 3;
    int cycle_count    = 0;
    int settings_used  = 1;
    logic [IN_W-1:0] batch[$];

    scalar_kalman_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // observe every transfer and register write at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid === 1'b1 && m_tready) begin
                scoreboard.check_count(m_tdata);
            end
            if (cfg_wr_en) begin
                scoreboard.write_reg(cfg_wr_index, cfg_wr_data);
            end
            if (s_tvalid && s_tready === 1'b1) begin
                scoreboard.take_sample(s_tdata);
            end
        end
    end

    // result side: random stall before each transfer, then hold ready until it happens
    initial begin : result_sink
        int stall;
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && aresetn));
        end
    end

    // valid stays high across back-to-back samples when no gap is drawn
    task automatic send_sample(input logic [IN_W-1:0] value);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic send_batch();
        foreach (batch[i]) begin
            send_sample(batch[i]);
        end
    endtask

    // enable is left high for back-to-back writes; end_writes drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // every sample yields a result, so the block is idle once nothing is owed
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (scoreboard.pending() != 0);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_W'(VAR_MAX);
            2:       return CFG_W'($urandom_range(1, 255));
            3:       return CFG_W'($urandom_range(0, VAR_MAX));
            4:       return CFG_W'($urandom_range(30000, 40000));
            default: return CFG_W'($urandom_range(256, 8191));
        endcase
    endfunction

    // random settings, then a run of encoder-like counts around a drifting centre
    task automatic random_phase(input int n);
        int centre;
        int v;
        if ($urandom_range(0, 1)) write_reg(REG_PROCESS_NOISE, pick_reg_value());
        if ($urandom_range(0, 1)) write_reg(REG_MEASUREMENT_NOISE, pick_reg_value());
        if ($urandom_range(0, 1)) write_reg(REG_INITIAL_VARIANCE, pick_reg_value());
        if ($urandom_range(0, 7) == 0) begin
            write_reg(REG_SPARE, CFG_W'($urandom_range(0, VAR_MAX)));
        end
        end_writes();
        src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 3;
        sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
        centre = int'($urandom_range(0, 65535)) - 32768;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1: v = int'($urandom_range(0, 65535)) - 32768;
                2: begin
                    case ($urandom_range(0, 4))
                        0:       v = 32767;
                        1:       v = -32768;
                        2:       v = 0;
                        3:       v = -1;
                        default: v = 1;
                    endcase
                end
                default: begin
                    // slow drift plus small jitter, as a real encoder gives
                    centre = centre + int'($urandom_range(0, 16)) - 8;
                    v = centre + int'($urandom_range(0, 127)) - 64;
                end
            endcase
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_sample(IN_W'(v));
        end
        drain();
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: field extremes, alternating bit patterns, a steady input
        batch = '{16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF,
                  16'h5555, 16'hAAAA, 16'd100, 16'd100, 16'd100, 16'hFF9C};
        send_batch();
        drain();

        // largest variances with the smallest nonzero R: gain near one, output limits
        write_reg(REG_PROCESS_NOISE, CFG_W'(VAR_MAX));
        write_reg(REG_MEASUREMENT_NOISE, CFG_W'(1));
        write_reg(REG_INITIAL_VARIANCE, CFG_W'(VAR_MAX));
        write_reg(REG_SPARE, CFG_W'(VAR_MAX));
        end_writes();
        batch = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'd12345};
        send_batch();
        drain();

        // all zero: prior plus R is zero, so the estimate must not move
        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_MEASUREMENT_NOISE, '0);
        write_reg(REG_INITIAL_VARIANCE, '0);
        end_writes();
        batch = '{16'd500, 16'hFE0C, 16'h7FFF};
        send_batch();
        drain();

        // R zero with a small variance: unity gain once, then the zero denominator again
        write_reg(REG_INITIAL_VARIANCE, CFG_W'(5));
        end_writes();
        batch = '{16'd7, 16'h8000, 16'h7FFF};
        send_batch();
        drain();

        repeat (26) random_phase(50);

        // room for any stray result after the last expected one
        repeat (2 * FRAC + 10) @(posedge aclk);

        $display("%0d samples over %0d register settings, %0d filtered counts compared",
                 scoreboard.samples_taken, settings_used, scoreboard.results_checked);
        $display("covered zero denominator, unity gain, output limits and variance reloads");
        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
